FILE: design/led_pwm_blink_frame_scanner_unit_assert.svh
// assertion macros shared by the led pwm blink frame scanner rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LED_PWM_BLINK_FRAME_SCANNER_UNIT_ASSERT_SVH
`define LED_PWM_BLINK_FRAME_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPBFS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LPBFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lpbfs_pkg.sv
// types, constants and the gamma table of the led pwm blink frame scanner
// no dependencies
`timescale 1ns / 1ps

package lpbfs_pkg;

  localparam int LedsPerDriver = 8;
  localparam int LumSteps      = 32;
  localparam int BlinkShift    = 5;

  localparam int LumW     = 5;
  localparam int BlinkW   = 8;
  localparam int StatusW  = 8;
  localparam int LevelW   = 4;
  localparam int LedIdxW  = 6;
  localparam int LaneW    = 3;
  localparam int DrvIdxW  = 3;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 8;

  // item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindTick  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOffCode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgOnCode  = CfgIdxW'(1);

  localparam logic [StatusW-1:0] OffCodeRst = StatusW'(0);
  localparam logic [StatusW-1:0] OnCodeRst  = StatusW'(1);

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LevelW-1:0]  level;
  } led_entry_t;

  // control handed from the sequencer to the row evaluator
  typedef struct packed {
    logic [StatusW-1:0] off_code;
    logic [StatusW-1:0] on_code;
    logic [LumW-1:0]    lum_phase;
    logic [BlinkW-1:0]  blink_phase;
    logic               dark;
  } eval_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } lpbfs_state_e;

  function automatic logic [LumW-1:0] gamma_lut(input logic [LevelW-1:0] lvl);
    logic [LumW-1:0] g;
    case (lvl)
      4'd0:    g = 5'd0;
      4'd1:    g = 5'd1;
      4'd2:    g = 5'd2;
      4'd3:    g = 5'd3;
      4'd4:    g = 5'd4;
      4'd5:    g = 5'd6;
      4'd6:    g = 5'd8;
      4'd7:    g = 5'd10;
      4'd8:    g = 5'd12;
      4'd9:    g = 5'd14;
      4'd10:   g = 5'd17;
      4'd11:   g = 5'd19;
      4'd12:   g = 5'd22;
      4'd13:   g = 5'd25;
      4'd14:   g = 5'd28;
      default: g = LumW'(LumSteps - 1);
    endcase
    return g;
  endfunction

endpackage

FILE: design/lpbfs_ifs.sv
// handshake channel interfaces: input items, driver bytes, register writes
// depends on lpbfs_pkg
`timescale 1ns / 1ps

interface lpbfs_in_if import lpbfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [LedIdxW-1:0] led_index;
  logic [StatusW-1:0] led_status;
  logic [LevelW-1:0]  led_level;
  logic               is_dark;

  modport source (output valid, kind, led_index, led_status, led_level, is_dark,
                  input ready);
  modport sink   (input valid, kind, led_index, led_status, led_level, is_dark,
                  output ready);
endinterface

interface lpbfs_out_if import lpbfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DrvIdxW-1:0] driver_index;
  logic [7:0]         driver_byte;
  logic               last;

  modport source (output valid, driver_index, driver_byte, last, input ready);
  modport sink   (input valid, driver_index, driver_byte, last, output ready);
endinterface

interface lpbfs_cfg_if import lpbfs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/lpbfs_row_eval.sv
// shared row evaluator: turns one driver row of led entries into a byte
// depends on lpbfs_pkg
`timescale 1ns / 1ps

module lpbfs_row_eval import lpbfs_pkg::*; (
  input  led_entry_t               row_i [LedsPerDriver],
  input  logic [LedsPerDriver-1:0] row_vld_i,
  input  eval_ctrl_t               ctrl_i,
  output logic [LedsPerDriver-1:0] byte_o
);

  led_entry_t      ent [LedsPerDriver];
  logic [LumW-1:0] eff [LedsPerDriver];
  logic [LedsPerDriver-1:0] lit;

  always_comb begin
    for (int p = 0; p < LedsPerDriver; p++) begin
      // entries never written read as zero
      ent[p] = row_vld_i[p] ? row_i[p] : '0;
      eff[p] = LumW'(ctrl_i.lum_phase + LumW'(p));
      lit[p] = (ent[p].status != ctrl_i.off_code)
            && (gamma_lut(ent[p].level) >= eff[p])
            && ((ent[p].status == ctrl_i.on_code)
                || ((ent[p].status & ctrl_i.blink_phase) != '0));
      // first led of the group lands in the msb
      byte_o[LedsPerDriver-1-p] = lit[p] & ~ctrl_i.dark;
    end
  end

endmodule

FILE: design/led_pwm_blink_frame_scanner_unit.sv
// top level of the led pwm blink frame scanner: sequencer, led store, counters
// depends on lpbfs_pkg, lpbfs_ifs, lpbfs_row_eval and the assertion header
`timescale 1ns / 1ps

// LED matrix scanner with pwm dimming and blink. A write transaction
// (kind 0) stores status and level for one led; an index at or beyond
// NUM_DRIVERS*8 is dropped. A tick transaction (kind 1) returns one byte
// per driver, driver 0 first, first led of each group in the msb, with
// last set on the final byte. For each driver the sequencer passes a read
// state, which registers the row from the led store, and then a send
// state, where the shared row evaluator presents its byte and which holds
// while the output is stalled. The input is not ready while a tick is in
// flight and comes back in the cycle after the final byte, so a new tick
// is taken only once every byte of the last one is out. The store is
// clear right after reset through per-entry valid bits, so no clearing
// pass runs. A dark tick returns all-zero bytes but still advances the
// luminosity phase, which wraps at 32 and then steps the blink counter;
// the blink phase is the blink counter shifted right by 5.

module led_pwm_blink_frame_scanner_unit import lpbfs_pkg::*; #(
  parameter int NUM_DRIVERS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpbfs_in_if.sink    in_i,
  lpbfs_out_if.source out_o,
  lpbfs_cfg_if.sink   cfg_i
);

`include "led_pwm_blink_frame_scanner_unit_assert.svh"

  localparam int LedCount = NUM_DRIVERS * LedsPerDriver;
  localparam int RowW     = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1;

  // sequencer state
  lpbfs_state_e state_q, state_d;
  logic [RowW-1:0] drv_q;
  logic            dark_q;

  // frame counters and registers
  logic [LumW-1:0]    lum_q;
  logic [BlinkW-1:0]  blink_q;
  logic [StatusW-1:0] off_code_q;
  logic [StatusW-1:0] on_code_q;

  // led store: one row per driver, lane writes, registered row read
  led_entry_t               mem_q [NUM_DRIVERS][LedsPerDriver];
  logic [LedsPerDriver-1:0] vld_q [NUM_DRIVERS];
  led_entry_t               rd_row_q [LedsPerDriver];
  logic [LedsPerDriver-1:0] rd_vld_q;

  // handshakes
  logic in_fire, out_fire, cfg_fire;
  logic wr_en, tick_start, drv_last;
  logic [RowW-1:0]  wr_row;
  logic [LaneW-1:0] wr_lane;

  eval_ctrl_t               ctrl;
  logic [LedsPerDriver-1:0] row_byte;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;
  assign cfg_fire = cfg_i.valid & cfg_i.ready;

  assign wr_en      = in_fire && (in_i.kind == KindWrite) && (32'(in_i.led_index) < LedCount);
  assign tick_start = in_fire && (in_i.kind == KindTick);
  assign wr_row     = RowW'(in_i.led_index[LedIdxW-1:LaneW]);
  assign wr_lane    = in_i.led_index[LaneW-1:0];
  assign drv_last   = (drv_q == RowW'(NUM_DRIVERS - 1));

  // register writes, unknown indexes do nothing
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_code_q <= OffCodeRst;
      on_code_q  <= OnCodeRst;
    end else if (cfg_fire) begin
      if (cfg_i.index == CfgOffCode) begin
        off_code_q <= cfg_i.data;
      end
      if (cfg_i.index == CfgOnCode) begin
        on_code_q <= cfg_i.data;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_o.ready) begin
          state_d = drv_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready  = 1'b1;
      ST_SEND: out_o.valid = 1'b1;
      default: begin
        in_i.ready  = 1'b0;
        out_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drv_q   <= '0;
      dark_q  <= 1'b0;
      lum_q   <= '0;
      blink_q <= '0;
    end else begin
      state_q <= state_d;
      if (tick_start) begin
        drv_q  <= '0;
        dark_q <= in_i.is_dark;
      end else if (out_fire && !drv_last) begin
        drv_q <= drv_q + RowW'(1);
      end
      // phase moves once the final byte of a tick has gone out
      if (out_fire && drv_last) begin
        lum_q <= lum_q + LumW'(1);
        if (lum_q == LumW'(LumSteps - 1)) begin
          blink_q <= blink_q + BlinkW'(1);
        end
      end
    end
  end

  // valid bits stand in for clearing the store at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_DRIVERS; r++) begin
        vld_q[r] <= '0;
      end
    end else if (wr_en) begin
      vld_q[wr_row][wr_lane] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_row][wr_lane] <= '{status: in_i.led_status, level: in_i.led_level};
    end
    if (state_q == ST_READ) begin
      rd_row_q <= mem_q[drv_q];
      rd_vld_q <= vld_q[drv_q];
    end
  end

  // one row evaluator serves every driver in turn
  assign ctrl = '{
    off_code:    off_code_q,
    on_code:     on_code_q,
    lum_phase:   lum_q,
    blink_phase: blink_q >> BlinkShift,
    dark:        dark_q
  };

  lpbfs_row_eval u_row_eval (
    .row_i     (rd_row_q),
    .row_vld_i (rd_vld_q),
    .ctrl_i    (ctrl),
    .byte_o    (row_byte)
  );

  assign out_o.driver_index = DrvIdxW'(drv_q);
  assign out_o.driver_byte  = row_byte;
  assign out_o.last         = drv_last;

  `LPBFS_ASSERT_IMPLIES(a_no_accept_while_sending, out_o.valid, !in_i.ready,
    "input accepted while a driver byte is pending")
  `LPBFS_ASSERT_IMPLIES(a_dark_bytes_zero, out_o.valid && dark_q,
    out_o.driver_byte == '0, "dark tick produced a lit bit")
  `LPBFS_ASSERT_IMPLIES(a_driver_in_range, state_q != ST_IDLE,
    32'(drv_q) < NUM_DRIVERS, "driver counter out of range")
  `LPBFS_ASSERT_NEXT(a_lum_steps_on_last, out_fire && drv_last,
    lum_q == LumW'($past(lum_q) + LumW'(1)), "luminosity phase did not advance")
  `LPBFS_ASSERT_NEXT(a_lum_holds_mid_tick, out_fire && !drv_last,
    $stable(lum_q) && $stable(blink_q), "frame counters moved mid tick")

endmodule
